// ===== rtl/bac_pkg.sv =====
// Shared constants, types and small count helpers for the border adjacency counter.
// Used by bac_pair_slot, border_adjacency_counter and the testbench; depends on nothing else.
`default_nettype none

package bac_pkg;

  localparam int NUM_COLORS  = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int COLOR_W     = 8;
  localparam int OUT_W       = 32;
  localparam int NUM_NB      = 8;
  localparam int NB_IDX_W    = 3;
  localparam int NB_CNT_W    = 4;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_MASKS   = 4;
  localparam int MASK_SEL_W  = 2;
  localparam int MASK_BIT_W  = 6;

  localparam int COLOR_AW  = $clog2(NUM_COLORS);
  localparam int NUM_PAIRS = NUM_COLORS * (NUM_COLORS - 1) / 2;
  localparam int PAIR_AW   = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
  localparam int CLR_LEN   = (NUM_PAIRS > NUM_COLORS) ? NUM_PAIRS : NUM_COLORS;
  localparam int CLR_W     = $clog2(CLR_LEN);

  localparam logic [COLOR_W:0] COLOR_LIMIT = (COLOR_W + 1)'(NUM_COLORS);

  typedef logic [COLOR_W-1:0]     color_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [PAIR_AW-1:0]     pair_addr_t;

  // Saturating increment of one counter.
  function automatic count_t sat_inc(count_t v);
    return (v == '1) ? v : v + COUNT_WIDTH'(1);
  endfunction

  // Query results are reported on 32 bits; wider counts clip at all ones.
  function automatic logic [OUT_W-1:0] clip_count(count_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w[63:OUT_W] != '0) ? '1 : w[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bac_pair_slot.sv =====
// Pair slot unit: orders two colors and forms the flat pair-counter address.
// Depends on bac_pkg; shared by the pair update loop and the pair query.
`default_nettype none

module bac_pair_slot (
  input  bac_pkg::color_t     a_i,
  input  bac_pkg::color_t     b_i,
  output bac_pkg::pair_addr_t slot_o,
  output logic                ok_o
);
  import bac_pkg::*;

  color_t                 lo;
  color_t                 hi;
  logic [2*COLOR_W-1:0]   prod;
  logic [2*COLOR_W-1:0]   sum;

  always_comb begin
    lo = (a_i < b_i) ? a_i : b_i;
    hi = (a_i < b_i) ? b_i : a_i;
    // Slot of pair (lo, hi) is lo + hi*(hi-1)/2.
    prod = (2*COLOR_W)'(hi) * (2*COLOR_W)'(hi - COLOR_W'(1));
    sum  = (prod >> 1) + (2*COLOR_W)'(lo);
  end

  assign slot_o = sum[PAIR_AW-1:0];
  assign ok_o   = (a_i != b_i) && ({1'b0, hi} < COLOR_LIMIT);

endmodule

`default_nettype wire

// ===== rtl/border_adjacency_counter.sv =====
// Top level of the border adjacency counter: sequencer, counter memories, result register.
// Depends on bac_pkg and bac_pair_slot.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one item: a window
// (centre plus eight neighbours) or a color or pair count query. The output
// channel (out_valid_o / out_stall_i) returns exactly one item per input item.
// The outer color set is written through cfg_we_i / cfg_idx_i / cfg_wdata_i.
// After reset a clearing pass zeroes both counter memories, one entry per
// cycle; the block stalls its input during that pass.
// Items are processed one at a time. A query reads its counter in the start
// state and loads its result in the finishing state. A window first counts its
// centre color; if the centre is outer, its eight neighbours are scanned, and if
// an inner color is among at least two distinct neighbor colors, each pair of
// them (up to 28 pairs) is counted: every pair is a read-modify-write through
// the single port pair of the pair-count memory, addressed by one shared slot
// unit. The next item is accepted only after the result is loaded.
// The result waits in an output register; a new item is accepted while it
// waits, and that item's result is held back until the register is taken.
// A stalled receiver therefore stops the block after at most one more item.
`default_nettype none

module border_adjacency_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bac_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bac_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  bac_pkg::color_t               centre_i,
  input  bac_pkg::color_t               nb_upper_left_i,
  input  bac_pkg::color_t               nb_up_i,
  input  bac_pkg::color_t               nb_upper_right_i,
  input  bac_pkg::color_t               nb_right_i,
  input  bac_pkg::color_t               nb_lower_right_i,
  input  bac_pkg::color_t               nb_down_i,
  input  bac_pkg::color_t               nb_lower_left_i,
  input  bac_pkg::color_t               nb_left_i,
  input  bac_pkg::color_t               query_color_a_i,
  input  bac_pkg::color_t               query_color_b_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          keep_original_o,
  output logic [bac_pkg::OUT_W-1:0]     count_value_o
);
  import bac_pkg::*;

  localparam logic [1:0] KIND_WINDOW  = 2'd0;
  localparam logic [1:0] KIND_COLOR_Q = 2'd1;
  localparam logic [1:0] KIND_PAIR_Q  = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_C_WR,
    ST_SCAN,
    ST_P_RD,
    ST_P_WR,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  // Outer color set.
  logic [CFG_W-1:0] mask_q [NUM_MASKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_MASKS; k++) mask_q[k] <= '0;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_MASKS))) begin
      mask_q[cfg_idx_i[MASK_SEL_W-1:0]] <= cfg_wdata_i;
    end
  end

  // Latched item.
  logic [1:0] kind_q;
  color_t     centre_q;
  color_t     nb_q [NUM_NB];
  color_t     qa_q;
  color_t     qb_q;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Sequencer registers.
  logic [NB_IDX_W-1:0] idx_q;
  logic [NB_CNT_W-1:0] n_q;
  logic [NB_IDX_W-1:0] i_q, j_q;
  logic                outer_found_q, inner_found_q;
  logic                keep_q;
  logic [CLR_W-1:0]    clr_q;
  logic                out_valid_q, out_keep_q;
  logic [OUT_W-1:0]    out_count_q;
  color_t              list_q [NUM_NB];
  pair_addr_t          waddr_q;
  logic                wok_q;

  // Membership lookups.
  logic   centre_outer;
  color_t scan_c;
  logic   scan_outer, scan_skip, scan_seen;
  logic   outer_found_d, inner_found_d;
  logic [NB_CNT_W-1:0] n_d;

  assign centre_outer = mask_q[centre_q[COLOR_W-1:MASK_BIT_W]][centre_q[MASK_BIT_W-1:0]];
  assign scan_c       = nb_q[idx_q];
  assign scan_outer   = mask_q[scan_c[COLOR_W-1:MASK_BIT_W]][scan_c[MASK_BIT_W-1:0]];
  assign scan_skip    = (scan_c == centre_q);

  always_comb begin
    scan_seen = 1'b0;
    for (int k = 0; k < NUM_NB; k++) begin
      if ((NB_CNT_W'(k) < n_q) && (list_q[k] == scan_c)) scan_seen = 1'b1;
    end
    outer_found_d = outer_found_q || (!scan_skip && scan_outer);
    inner_found_d = inner_found_q || (!scan_skip && !scan_outer);
    n_d           = (!scan_skip && !scan_seen) ? n_q + NB_CNT_W'(1) : n_q;
  end

  // Shared pair slot unit: list pair during the update loop, else the query pair.
  color_t     slot_a, slot_b;
  pair_addr_t slot;
  logic       slot_ok;

  assign slot_a = (state_q == ST_P_RD) ? list_q[i_q] : qa_q;
  assign slot_b = (state_q == ST_P_RD) ? list_q[j_q] : qb_q;

  bac_pair_slot u_slot (
    .a_i    (slot_a),
    .b_i    (slot_b),
    .slot_o (slot),
    .ok_o   (slot_ok)
  );

  // Loop bounds.
  logic j_last, pair_last, clr_last, out_free;
  logic centre_ok, qa_ok;

  assign j_last    = ({1'b0, j_q} == n_q - NB_CNT_W'(1));
  assign pair_last = j_last && ({1'b0, i_q} == n_q - NB_CNT_W'(2));
  assign clr_last  = (clr_q == CLR_W'(CLR_LEN - 1));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign centre_ok = ({1'b0, centre_q} < COLOR_LIMIT);
  assign qa_ok     = ({1'b0, qa_q} < COLOR_LIMIT);

  // Color count memory.
  count_t               cmem [NUM_COLORS];
  count_t               crd_q;
  logic                 c_re, c_we;
  logic [COLOR_AW-1:0]  c_ra, c_wa;
  count_t               c_wd;

  // Pair count memory.
  count_t     pmem [NUM_PAIRS];
  count_t     prd_q;
  logic       p_re, p_we;
  pair_addr_t p_wa;
  count_t     p_wd;

  always_comb begin
    c_ra = (kind_q == KIND_WINDOW) ? centre_q[COLOR_AW-1:0] : qa_q[COLOR_AW-1:0];
    c_re = (state_q == ST_START) &&
           (((kind_q == KIND_WINDOW) && centre_ok) || ((kind_q == KIND_COLOR_Q) && qa_ok));
    c_we = 1'b0;
    c_wa = centre_q[COLOR_AW-1:0];
    c_wd = sat_inc(crd_q);
    p_re = slot_ok && ((state_q == ST_P_RD) ||
                       ((state_q == ST_START) && (kind_q == KIND_PAIR_Q)));
    p_we = 1'b0;
    p_wa = waddr_q;
    p_wd = sat_inc(prd_q);
    if (state_q == ST_CLEAR) begin
      c_we = ({1'b0, clr_q} < (CLR_W + 1)'(NUM_COLORS));
      c_wa = clr_q[COLOR_AW-1:0];
      c_wd = '0;
      p_we = ({1'b0, clr_q} < (CLR_W + 1)'(NUM_PAIRS));
      p_wa = clr_q[PAIR_AW-1:0];
      p_wd = '0;
    end else if (state_q == ST_C_WR) begin
      c_we = centre_ok;
    end else if (state_q == ST_P_WR) begin
      p_we = wok_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_re) crd_q <= cmem[c_ra];
    if (c_we) cmem[c_wa] <= c_wd;
  end

  always_ff @(posedge clk_i) begin
    if (p_re) prd_q <= pmem[slot];
    if (p_we) pmem[p_wa] <= p_wd;
  end

  // Result value for the item that finishes.
  logic [OUT_W-1:0] res_count;

  always_comb begin
    unique case (kind_q)
      KIND_COLOR_Q: res_count = qa_ok ? clip_count(crd_q) : '0;
      KIND_PAIR_Q:  res_count = slot_ok ? clip_count(prd_q) : '0;
      KIND_WINDOW:  res_count = '0;
      KIND_UNUSED:  res_count = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_START;
      ST_START: state_d = (kind_q == KIND_WINDOW) ? ST_C_WR : ST_DONE;
      ST_C_WR:  state_d = centre_outer ? ST_SCAN : ST_DONE;
      ST_SCAN: begin
        if (idx_q == NB_IDX_W'(NUM_NB - 1)) begin
          state_d = (inner_found_d && (n_d >= NB_CNT_W'(2))) ? ST_P_RD : ST_DONE;
        end
      end
      ST_P_RD:  state_d = ST_P_WR;
      ST_P_WR:  state_d = pair_last ? ST_DONE : ST_P_RD;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Item payload and the distinct-color list.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_i;
      centre_q <= centre_i;
      nb_q[0]  <= nb_upper_left_i;
      nb_q[1]  <= nb_up_i;
      nb_q[2]  <= nb_upper_right_i;
      nb_q[3]  <= nb_right_i;
      nb_q[4]  <= nb_lower_right_i;
      nb_q[5]  <= nb_down_i;
      nb_q[6]  <= nb_lower_left_i;
      nb_q[7]  <= nb_left_i;
      qa_q     <= query_color_a_i;
      qb_q     <= query_color_b_i;
    end
    if ((state_q == ST_SCAN) && !scan_skip && !scan_seen) begin
      list_q[n_q[NB_IDX_W-1:0]] <= scan_c;
    end
    if (state_q == ST_P_RD) begin
      waddr_q <= slot;
      wok_q   <= slot_ok;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      idx_q         <= '0;
      n_q           <= '0;
      i_q           <= '0;
      j_q           <= '0;
      outer_found_q <= 1'b0;
      inner_found_q <= 1'b0;
      keep_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      out_keep_q    <= 1'b0;
      out_count_q   <= '0;
    end else begin
      state_q <= state_d;
      // The finishing step reloads the result register itself.
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          if (!clr_last) clr_q <= clr_q + CLR_W'(1);
        end
        ST_IDLE: begin
        end
        ST_START: begin
          idx_q         <= '0;
          n_q           <= '0;
          outer_found_q <= 1'b0;
          inner_found_q <= 1'b0;
          keep_q        <= 1'b0;
        end
        ST_C_WR: begin
        end
        ST_SCAN: begin
          idx_q         <= idx_q + NB_IDX_W'(1);
          n_q           <= n_d;
          outer_found_q <= outer_found_d;
          inner_found_q <= inner_found_d;
          if (idx_q == NB_IDX_W'(NUM_NB - 1)) begin
            keep_q <= outer_found_d || !inner_found_d;
            i_q    <= '0;
            j_q    <= NB_IDX_W'(1);
          end
        end
        ST_P_RD: begin
        end
        ST_P_WR: begin
          // Walk the pairs i < j of the list row by row.
          if (j_last) begin
            i_q <= i_q + NB_IDX_W'(1);
            j_q <= i_q + NB_IDX_W'(2);
          end else begin
            j_q <= j_q + NB_IDX_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_keep_q  <= keep_q;
            out_count_q <= res_count;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign keep_original_o = out_keep_q;
  assign count_value_o   = out_count_q;

  // The pair walk stays inside the collected list.
  a_pair_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P_RD) |-> ((i_q < j_q) && ({1'b0, j_q} < n_q)))
    else $error("pair walk left the collected color list");

  // Collected colors are distinct, so every walked pair has two colors.
  a_pair_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P_RD) |-> (list_q[i_q] != list_q[j_q]))
    else $error("collected color list holds a repeated color");

  // A result only appears after the sequencer finished an item.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside the finishing step");

endmodule

`default_nettype wire

// ===== dv/bac_tb_pkg.sv =====
// Item kinds, register indexes and the input item layout shared by the
// border adjacency counter testbench top and its checker. Depends on bac_pkg.
package bac_tb_pkg;
  import bac_pkg::*;

  typedef enum logic [1:0] {
    KIND_WINDOW      = 2'd0,
    KIND_COLOR_QUERY = 2'd1,
    KIND_PAIR_QUERY  = 2'd2,
    KIND_UNUSED      = 2'd3
  } item_kind_e;

  localparam logic [CFG_IDX_W-1:0] REG_OUTER_MASK_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_MASK_1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_MASK_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_MASK_3 = CFG_IDX_W'(3);

  // Neighbors are stored upper left first, going clockwise, left last.
  typedef struct packed {
    item_kind_e             kind;
    color_t                 centre;
    color_t [NUM_NB-1:0]    nbs;
    color_t                 query_a;
    color_t                 query_b;
  } bac_item_t;

endpackage

// ===== dv/bac_tally_checker.sv =====
// Checker for the border adjacency counter: keeps its own color and pair tallies,
// predicts one result per accepted item and compares it with the block's output.
// Depends on bac_pkg and bac_tb_pkg.
module bac_tally_checker
  import bac_pkg::*;
  import bac_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  bac_item_t            item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 keep_original_i,
  input  logic [OUT_W-1:0]     count_value_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o
);

  typedef struct packed {
    logic             keep;
    logic [OUT_W-1:0] count;
  } bac_result_t;

  logic [NUM_MASKS*CFG_W-1:0] outer_set;
  count_t                     color_tally [NUM_COLORS];
  count_t                     pair_tally [NUM_PAIRS];
  bac_result_t                due_results [$];
  int                         fails;
  int                         checked;

  function automatic count_t bumped(count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  function automatic logic [OUT_W-1:0] as_reported(count_t v);
    logic [63:0] w;
    w = 64'(v);
    return ((w >> OUT_W) != 0) ? '1 : w[OUT_W-1:0];
  endfunction

  function automatic int unsigned pair_index(color_t lo, color_t hi);
    return int'(lo) + int'(hi) * (int'(hi) - 1) / 2;
  endfunction

  // Applies one item to the tallies and returns the result it must produce.
  function automatic bac_result_t tally_item(bac_item_t it);
    bac_result_t r;
    color_t      found [NUM_NB];
    int          n;
    logic        dup;
    logic        outer_hit;
    logic        inner_hit;
    color_t      c;
    color_t      lo;
    color_t      hi;
    r = '0;
    n = 0;
    outer_hit = 1'b0;
    inner_hit = 1'b0;
    case (it.kind)
      KIND_WINDOW: begin
        if (int'(it.centre) < NUM_COLORS) begin
          color_tally[it.centre] = bumped(color_tally[it.centre]);
        end
        if (outer_set[it.centre]) begin
          for (int i = 0; i < NUM_NB; i++) begin
            c = it.nbs[i];
            if (c != it.centre) begin
              dup = 1'b0;
              for (int j = 0; j < n; j++) begin
                if (found[j] == c) dup = 1'b1;
              end
              if (!dup) begin
                found[n] = c;
                n++;
              end
              if (outer_set[c]) outer_hit = 1'b1;
              else inner_hit = 1'b1;
            end
          end
          r.keep = outer_hit || !inner_hit;
          // Adjacent pairs only count where the border touches an inner color.
          if (inner_hit) begin
            for (int i = 0; i < n; i++) begin
              for (int j = i + 1; j < n; j++) begin
                lo = (found[i] < found[j]) ? found[i] : found[j];
                hi = (found[i] < found[j]) ? found[j] : found[i];
                if (int'(hi) < NUM_COLORS) begin
                  pair_tally[pair_index(lo, hi)] = bumped(pair_tally[pair_index(lo, hi)]);
                end
              end
            end
          end
        end
      end
      KIND_COLOR_QUERY: begin
        if (int'(it.query_a) < NUM_COLORS) r.count = as_reported(color_tally[it.query_a]);
      end
      KIND_PAIR_QUERY: begin
        if (it.query_a != it.query_b) begin
          lo = (it.query_a < it.query_b) ? it.query_a : it.query_b;
          hi = (it.query_a < it.query_b) ? it.query_b : it.query_a;
          if (int'(hi) < NUM_COLORS) r.count = as_reported(pair_tally[pair_index(lo, hi)]);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bac_result_t want;
    if (!rst_ni) begin
      outer_set = '0;
      for (int i = 0; i < NUM_COLORS; i++) color_tally[i] = '0;
      for (int i = 0; i < NUM_PAIRS; i++) pair_tally[i] = '0;
      due_results.delete();
      fails = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i <= REG_OUTER_MASK_3) begin
        outer_set[cfg_idx_i * CFG_W +: CFG_W] = cfg_wdata_i;
      end
      // Results are taken before new items so that a stray result is never
      // matched against an item accepted at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result with no item outstanding: keep_original %0d, count_value %0d",
                 keep_original_i, count_value_i);
          fails++;
        end else begin
          want = due_results.pop_front();
          checked++;
          if (keep_original_i !== want.keep) begin
            $error("keep_original: expected %0d, actual %0d", want.keep, keep_original_i);
            fails++;
          end
          if (count_value_i !== want.count) begin
            $error("count_value: expected %0d, actual %0d", want.count, count_value_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) due_results.push_back(tally_item(item_i));
      fail_count_o <= fails;
      pending_o <= due_results.size();
      checked_o <= checked;
    end
  end

endmodule

// ===== dv/tb_border_adjacency_counter.sv =====
// Testbench top for the border adjacency counter: clock, reset, outer color set
// programming, window and query stimulus, receiver stalls and the verdict.
// Depends on bac_pkg, bac_tb_pkg, bac_tally_checker and border_adjacency_counter.
module tb_border_adjacency_counter;
  import bac_pkg::*;
  import bac_tb_pkg::*;

  localparam int SET_W           = NUM_MASKS * CFG_W;
  localparam int PAL_SIZE        = 12;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int HOLD_AFTER      = 400;
  localparam int HOLD_CYCLES     = 600;
  // The limit must outlast the quiet clearing pass after reset.
  localparam int IDLE_LIMIT      = 120000;
  localparam int DRAIN_CYCLES    = 100;

  typedef enum {SET_EMPTY, SET_FULL, SET_SPARSE, SET_RANDOM, SET_DENSE} outer_shape_e;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  bac_item_t            stim;
  logic                 out_valid;
  logic                 out_stall;
  logic                 keep_original;
  logic [OUT_W-1:0]     count_value;
  int                   fail_count;
  int                   pending;
  int                   checked;

  int                   taken;
  int                   burst_left;
  int                   windows;
  int                   outer_windows;
  int                   color_queries;
  int                   pair_queries;
  int                   settings;
  logic [SET_W-1:0]     outer_bits;
  color_t               pal [PAL_SIZE];

  border_adjacency_counter i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (stim.kind),
    .centre_i         (stim.centre),
    .nb_upper_left_i  (stim.nbs[0]),
    .nb_up_i          (stim.nbs[1]),
    .nb_upper_right_i (stim.nbs[2]),
    .nb_right_i       (stim.nbs[3]),
    .nb_lower_right_i (stim.nbs[4]),
    .nb_down_i        (stim.nbs[5]),
    .nb_lower_left_i  (stim.nbs[6]),
    .nb_left_i        (stim.nbs[7]),
    .query_color_a_i  (stim.query_a),
    .query_color_b_i  (stim.query_b),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .keep_original_o  (keep_original),
    .count_value_o    (count_value)
  );

  bac_tally_checker i_tally_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .item_i          (stim),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .keep_original_i (keep_original),
    .count_value_i   (count_value),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bac_item_t make_item(item_kind_e k, color_t c, logic [63:0] nbs,
                                          color_t a, color_t b);
    bac_item_t it;
    it.kind = k;
    it.centre = c;
    it.nbs = nbs;
    it.query_a = a;
    it.query_b = b;
    return it;
  endfunction

  // Picks an outer set of the given shape and a palette to draw colors from.
  // For the mixed shapes the first half of the palette is forced outer and
  // the second half inner, so that windows reach the pair counting.
  function automatic logic [SET_W-1:0] build_outer_set(outer_shape_e s);
    logic [SET_W-1:0] bits;
    logic [31:0]      w;
    bits = '0;
    if (s == SET_FULL) begin
      bits = '1;
    end else if (s != SET_EMPTY) begin
      for (int k = 0; k < SET_W / 32; k++) begin
        w = $urandom;
        if (s == SET_SPARSE) w = w & $urandom & $urandom;
        else if (s == SET_DENSE) w = w | $urandom;
        bits[k*32 +: 32] = w;
      end
    end
    for (int i = 0; i < PAL_SIZE; i++) begin
      pal[i] = color_t'($urandom_range(0, 255));
      if (s != SET_EMPTY && s != SET_FULL) bits[pal[i]] = (i < PAL_SIZE / 2);
    end
    return bits;
  endfunction

  function automatic bac_item_t random_item();
    logic [95:0]  raw;
    bac_item_t    it;
    int unsigned  pick;
    logic         outer_only;
    for (int k = 0; k < 3; k++) raw[k*32 +: 32] = $urandom;
    it = raw[$bits(bac_item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.kind = KIND_WINDOW;
      if ($urandom_range(0, 9) < 8) it.centre = pal[$urandom_range(0, PAL_SIZE / 2 - 1)];
      outer_only = ($urandom_range(0, 9) == 0);
      for (int n = 0; n < NUM_NB; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) it.nbs[n] = it.centre;
        else if (pick < 9) begin
          it.nbs[n] = outer_only ? pal[$urandom_range(0, PAL_SIZE / 2 - 1)]
                                 : pal[$urandom_range(0, PAL_SIZE - 1)];
        end
      end
    end else if (pick < 80) begin
      it.kind = KIND_COLOR_QUERY;
      if ($urandom_range(0, 4) != 0) it.query_a = pal[$urandom_range(0, PAL_SIZE - 1)];
    end else if (pick < 98) begin
      it.kind = KIND_PAIR_QUERY;
      if ($urandom_range(0, 4) != 0) it.query_a = pal[$urandom_range(0, PAL_SIZE - 1)];
      if ($urandom_range(0, 4) != 0) it.query_b = pal[$urandom_range(0, PAL_SIZE - 1)];
      if ($urandom_range(0, 19) == 0) it.query_b = it.query_a;
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  // Called only while no item is offered and nothing is outstanding.
  task automatic write_outer_set(input logic [SET_W-1:0] bits);
    for (int r = 0; r < NUM_MASKS; r++) begin
      cfg_we <= 1'b1;
      cfg_idx <= REG_OUTER_MASK_0 + CFG_IDX_W'(r);
      cfg_wdata <= bits[r*CFG_W +: CFG_W];
      @(posedge clk);
    end
    // An index past the last mask register must leave the set untouched.
    cfg_idx <= CFG_IDX_W'($urandom_range(REG_OUTER_MASK_3 + 1, 2**CFG_IDX_W - 1));
    cfg_wdata <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
    outer_bits = bits;
    settings++;
  endtask

  task automatic offer(input bac_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    stim <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    case (it.kind)
      KIND_WINDOW: begin
        windows++;
        if (outer_bits[it.centre]) outer_windows++;
      end
      KIND_COLOR_QUERY: color_queries++;
      KIND_PAIR_QUERY:  pair_queries++;
      default: begin
      end
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: changes its stall pattern after runs of random length and once
  // holds off long enough for the block to back up into its input.
  initial begin : receiver
    int   mode;
    int   left;
    logic hold_done;
    out_stall = 1'b0;
    mode = 0;
    left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(32, 256);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 7) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) taken <= taken + 1;
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("border_adjacency_counter test failed");
    $finish;
  end

  initial begin : stimulus
    bac_item_t        script [$];
    logic [SET_W-1:0] bits;
    outer_shape_e     plan [7];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    stim = '0;
    outer_bits = '0;
    plan = '{SET_RANDOM, SET_EMPTY, SET_DENSE, SET_FULL, SET_SPARSE, SET_RANDOM, SET_RANDOM};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Colors 0 to 63 and 255 form the border for the directed items.
    bits = '0;
    bits[63:0] = '1;
    bits[255] = 1'b1;
    write_outer_set(bits);

    script.push_back(make_item(KIND_WINDOW, 8'd10, {8{8'd10}}, 8'd0, 8'd0));
    script.push_back(make_item(KIND_WINDOW, 8'd10,
      {8'd20, 8'd200, 8'd20, 8'd200, 8'd10, 8'd10, 8'd255, 8'd64}, 8'd0, 8'd0));
    script.push_back(make_item(KIND_WINDOW, 8'd10, {8{8'd200}}, 8'd0, 8'd0));
    script.push_back(make_item(KIND_WINDOW, 8'd10,
      {8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18}, 8'd0, 8'd0));
    script.push_back(make_item(KIND_WINDOW, 8'd255,
      {8'd0, 8'd128, 8'd129, 8'd254, 8'd1, 8'd130, 8'd131, 8'd132}, 8'd0, 8'd0));
    script.push_back(make_item(KIND_WINDOW, 8'd0, {8{8'd255}}, 8'd255, 8'd255));
    script.push_back(make_item(KIND_WINDOW, 8'd128,
      {8'd0, 8'd1, 8'd2, 8'd3, 8'd129, 8'd130, 8'd131, 8'd128}, 8'd0, 8'd0));
    script.push_back(make_item(KIND_WINDOW, 8'd63, {8{8'd64}}, 8'd0, 8'd0));
    script.push_back(make_item(KIND_WINDOW, 8'd255, {8{8'd0}}, 8'd0, 8'd0));
    script.push_back(make_item(KIND_WINDOW, 8'd255, {8{8'd255}}, 8'd0, 8'd0));
    script.push_back(make_item(KIND_COLOR_QUERY, 8'd0, 64'd0, 8'd10, 8'd0));
    script.push_back(make_item(KIND_COLOR_QUERY, 8'd0, 64'd0, 8'd255, 8'd255));
    script.push_back(make_item(KIND_COLOR_QUERY, 8'd0, 64'd0, 8'd0, 8'd0));
    script.push_back(make_item(KIND_COLOR_QUERY, 8'd0, 64'd0, 8'd127, 8'd0));
    script.push_back(make_item(KIND_PAIR_QUERY, 8'd0, 64'd0, 8'd20, 8'd200));
    script.push_back(make_item(KIND_PAIR_QUERY, 8'd0, 64'd0, 8'd200, 8'd20));
    script.push_back(make_item(KIND_PAIR_QUERY, 8'd0, 64'd0, 8'd255, 8'd20));
    script.push_back(make_item(KIND_PAIR_QUERY, 8'd0, 64'd0, 8'd0, 8'd254));
    script.push_back(make_item(KIND_PAIR_QUERY, 8'd0, 64'd0, 8'd132, 8'd0));
    script.push_back(make_item(KIND_PAIR_QUERY, 8'd0, 64'd0, 8'd7, 8'd7));
    script.push_back(make_item(KIND_PAIR_QUERY, 8'd0, 64'd0, 8'd255, 8'd255));
    script.push_back(make_item(KIND_PAIR_QUERY, 8'd0, 64'd0, 8'd0, 8'd255));
    script.push_back(make_item(KIND_UNUSED, 8'd255, '1, 8'd255, 8'd255));
    foreach (script[i]) offer(script[i]);

    foreach (plan[p]) begin
      wait_drained();
      write_outer_set(build_outer_set(plan[p]));
      repeat (ITEMS_PER_PHASE) offer(random_item());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d windows (%0d with an outer centre), %0d color queries,",
             checked, windows, outer_windows, color_queries);
    $display("%0d pair queries, across %0d outer color sets and one %0d-cycle receiver hold-off.",
             pair_queries, settings, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("border_adjacency_counter test passed");
    end else begin
      $display("border_adjacency_counter test failed");
    end
    $finish;
  end

endmodule
